// File: design/wnpf_pkg.sv
package wnpf_pkg;

  localparam int MaxPoints = 64;
  localparam int AddrW     = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int CntW      = $clog2(MaxPoints + 1);

  localparam int EntryW   = 32;
  localparam int LonW     = 15;
  localparam int LatW     = 14;
  localparam int CountW   = 7;
  localparam int LimW     = 15;
  localparam int IdxW     = 6;
  localparam int DistW    = 15;
  localparam int OpacW    = 9;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 15;

  localparam int DeltaW = 14;
  localparam int SqW    = 2 * DeltaW;
  localparam int D2W    = 30;
  localparam int RootW  = D2W / 2;
  localparam int SqStepW = $clog2(RootW);
  localparam int QuoW   = 18;
  localparam int QuoStepW = $clog2(QuoW);

  localparam logic [LonW-1:0]          HalfTurn     = 15'd11520;
  localparam logic signed [LonW+1:0]   FullTurnS    = 17'sd23040;
  localparam logic [DistW-1:0]         FullTurnDist = 15'd23040;
  localparam logic [D2W-1:0]           FullTurnSq   = 30'd530841600;
  localparam logic [QuoW-1:0]          FadeOne      = 18'd65536;
  localparam logic [LimW-1:0]          LimitReset   = 15'd640;

  typedef enum logic {
    CmdWrite = 1'b0,
    CmdQuery = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPointCount = 1'b0,
    CfgDistLimit  = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    TopIdle,
    TopScan,
    TopFade,
    TopOut
  } top_state_e;

  typedef enum logic [2:0] {
    FadeIdle,
    FadeRoot,
    FadeDiv,
    FadeClamp,
    FadeOpac
  } fade_state_e;

  typedef struct packed {
    logic [D2W-1:0]   best2;
    logic [AddrW-1:0] idx;
    logic             found;
  } scan_res_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             in_limit;
    logic [OpacW-1:0] opacity;
  } fade_res_t;

endpackage

// File: design/wnpf_ram.sv
module wnpf_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/wnpf_isqrt.sv
module wnpf_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wnpf_pkg::D2W-1:0]    radicand_i,
  output logic                        done_o,
  output logic [wnpf_pkg::RootW-1:0]  root_o
);
  import wnpf_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [SqStepW-1:0] step_q;
  logic [D2W-1:0]     rad_q;
  logic [RootW+2:0]   rem_q;
  logic [RootW-1:0]   root_q;

  logic [RootW+2:0] rem_sh;
  logic [RootW+2:0] trial;
  logic             ge;

  assign rem_sh = {rem_q[RootW:0], rad_q[D2W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= SqStepW'(RootW - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[D2W-3:0], 2'b00};
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[RootW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: design/wnpf_scan.sv
module wnpf_scan (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [wnpf_pkg::LonW-1:0]  qlon_i,
  input  logic signed [wnpf_pkg::LatW-1:0]  qlat_i,
  input  logic [wnpf_pkg::CountW-1:0]       count_i,
  output logic [wnpf_pkg::AddrW-1:0]        raddr_o,
  input  logic [wnpf_pkg::EntryW-1:0]       rdata_i,
  output logic                              done_o,
  output wnpf_pkg::scan_res_t               res_o
);
  import wnpf_pkg::*;

  logic                   busy_q;
  logic [CntW-1:0]        cnt_q;
  logic [CntW-1:0]        last_q;
  logic signed [LonW-1:0] qlon_q;
  logic signed [LatW-1:0] qlat_q;
  logic                   v0_q, v1_q, v2_q;
  logic [AddrW-1:0]       idx0_q, idx1_q, idx2_q;
  logic [DeltaW-1:0]      dx_q, dy_q;
  logic [SqW-1:0]         sqx_q, sqy_q;
  scan_res_t              res_q;

  logic                   issue;
  logic signed [LonW-1:0] plon;
  logic signed [LatW-1:0] plat;
  logic signed [LonW:0]   lon_diff, lon_neg;
  logic [LonW-1:0]        lon_abs;
  logic signed [LonW+1:0] wrap_diff, wrap_neg;
  logic [DeltaW-1:0]      wrap_abs;
  logic signed [LatW:0]   lat_diff, lat_neg;
  logic [DeltaW-1:0]      dx_d, dy_d;
  logic [D2W-1:0]         d2;

  assign issue   = busy_q && (cnt_q != last_q);
  assign raddr_o = cnt_q[AddrW-1:0];
  assign done_o  = busy_q && !issue && !v0_q && !v1_q && !v2_q;

  assign plon      = rdata_i[LonW-1:0];
  assign plat      = rdata_i[LonW+LatW-1:LonW];
  assign lon_diff  = {qlon_q[LonW-1], qlon_q} - {plon[LonW-1], plon};
  assign lon_neg   = -lon_diff;
  assign lon_abs   = lon_diff[LonW] ? lon_neg[LonW-1:0] : lon_diff[LonW-1:0];
  assign wrap_diff = FullTurnS - signed'({2'b00, lon_abs});
  assign wrap_neg  = -wrap_diff;
  assign wrap_abs  = wrap_diff[LonW+1] ? wrap_neg[DeltaW-1:0] : wrap_diff[DeltaW-1:0];
  assign dx_d      = (lon_abs >= HalfTurn) ? wrap_abs : lon_abs[DeltaW-1:0];
  assign lat_diff  = {qlat_q[LatW-1], qlat_q} - {plat[LatW-1], plat};
  assign lat_neg   = -lat_diff;
  assign dy_d      = lat_diff[LatW] ? lat_neg[DeltaW-1:0] : lat_diff[DeltaW-1:0];
  assign d2        = D2W'(sqx_q) + D2W'(sqy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      last_q <= '0;
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
    end else begin
      v0_q <= issue;
      v1_q <= v0_q;
      v2_q <= v1_q;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        last_q <= (int'(count_i) > MaxPoints) ? CntW'(MaxPoints) : CntW'(count_i);
      end else if (done_o) begin
        busy_q <= 1'b0;
      end else if (issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qlon_q      <= qlon_i;
      qlat_q      <= qlat_i;
      res_q.best2 <= FullTurnSq;
      res_q.idx   <= '0;
      res_q.found <= 1'b0;
    end else if (v2_q && (d2 < res_q.best2)) begin
      res_q.best2 <= d2;
      res_q.idx   <= idx2_q;
      res_q.found <= 1'b1;
    end
    idx0_q <= cnt_q[AddrW-1:0];
    idx1_q <= idx0_q;
    idx2_q <= idx1_q;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    sqx_q  <= SqW'(dx_q) * SqW'(dx_q);
    sqy_q  <= SqW'(dy_q) * SqW'(dy_q);
  end

  assign res_o = res_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("Scan started while a search is running.");

endmodule

// File: design/wnpf_fade.sv
module wnpf_fade (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  wnpf_pkg::scan_res_t        scan_i,
  input  logic [wnpf_pkg::LimW-1:0]  lim_i,
  output logic                       done_o,
  output wnpf_pkg::fade_res_t        res_o
);
  import wnpf_pkg::*;

  fade_state_e         state_q, state_d;
  logic                done_q, done_d;
  logic [D2W-1:0]      best2_q;
  logic [LimW-1:0]     lim_q;
  logic [D2W-1:0]      lim_sq_q;
  logic [LimW:0]       rem_q;
  logic [QuoW-1:0]     quo_q;
  logic [QuoStepW-1:0] step_q;
  fade_res_t           res_q;

  logic            sq_start;
  logic [D2W-1:0]  sq_rad;
  logic            sq_done;
  logic [RootW-1:0] sq_root;
  logic            in_limit;
  logic            div_ge;
  logic [LimW:0]   div_rem;

  wnpf_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sq_rad),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  assign in_limit = (best2_q < lim_sq_q);
  assign div_ge   = (rem_q >= {1'b0, lim_q});
  assign div_rem  = div_ge ? (rem_q - {1'b0, lim_q}) : rem_q;

  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    sq_start = 1'b0;
    sq_rad   = scan_i.best2;
    case (state_q)
      FadeIdle: begin
        if (start_i) begin
          if (scan_i.found) begin
            sq_start = 1'b1;
            state_d  = FadeRoot;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      FadeRoot: begin
        if (sq_done) begin
          if (in_limit) begin
            state_d = FadeDiv;
          end else begin
            done_d  = 1'b1;
            state_d = FadeIdle;
          end
        end
      end
      FadeDiv: begin
        if (step_q == '0) begin
          state_d = FadeClamp;
        end
      end
      FadeClamp: begin
        sq_start = 1'b1;
        sq_rad   = D2W'((quo_q > FadeOne) ? FadeOne : quo_q);
        state_d  = FadeOpac;
      end
      FadeOpac: begin
        if (sq_done) begin
          done_d  = 1'b1;
          state_d = FadeIdle;
        end
      end
      default: begin
        state_d = FadeIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FadeIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      FadeIdle: begin
        if (start_i) begin
          best2_q        <= scan_i.best2;
          lim_q          <= lim_i;
          lim_sq_q       <= D2W'(lim_i) * D2W'(lim_i);
          res_q.distance <= FullTurnDist;
          res_q.in_limit <= 1'b0;
          res_q.opacity  <= '0;
        end
      end
      FadeRoot: begin
        if (sq_done) begin
          res_q.distance <= sq_root[DistW-1:0];
          res_q.in_limit <= in_limit;
          rem_q          <= {1'b0, lim_q} - {1'b0, sq_root[DistW-1:0]};
          quo_q          <= '0;
          step_q         <= QuoStepW'(QuoW - 1);
        end
      end
      FadeDiv: begin
        rem_q  <= {div_rem[LimW-1:0], 1'b0};
        quo_q  <= {quo_q[QuoW-2:0], div_ge};
        step_q <= step_q - 1'b1;
      end
      FadeOpac: begin
        if (sq_done) begin
          res_q.opacity <= sq_root[OpacW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_opacity_needs_within: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (res_q.opacity != '0)) |-> res_q.in_limit)
    else $error("Nonzero opacity reported outside the distance limit.");

  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == FadeIdle))
    else $error("Fade result reported while the unit is still busy.");

endmodule

// File: design/wrapped_nearest_point_fade.sv
// A write request yields no result; requests are handled one at a time.
// A query scans N points, N being the point count clamped to 64:
// the memory scan reads one entry per cycle, then a shared bit-serial square root
// (run twice) and a restoring divide produce distance and opacity.
// Past the limit the divide and second root are skipped; with point count 0 all three are.
// Reset clears control and the config registers (point count 0, limit 640); the table is undefined.
module wrapped_nearest_point_fade (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic [wnpf_pkg::IdxW-1:0]         entry_index_i,
  input  logic signed [wnpf_pkg::LonW-1:0]  longitude_i,
  input  logic signed [wnpf_pkg::LatW-1:0]  latitude_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [wnpf_pkg::IdxW-1:0]         nearest_index_o,
  output logic [wnpf_pkg::DistW-1:0]        nearest_distance_o,
  output logic                              found_o,
  output logic                              within_limit_o,
  output logic [wnpf_pkg::OpacW-1:0]        opacity_o,
  input  logic                              cfg_we_i,
  input  logic [wnpf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [wnpf_pkg::CfgDataW-1:0]     cfg_wdata_i
);
  import wnpf_pkg::*;

  top_state_e        state_q, state_d;
  logic [CountW-1:0] point_count_q;
  logic [LimW-1:0]   dist_limit_q;
  logic              out_valid_q, out_valid_d;
  logic [IdxW-1:0]   nearest_index_q;
  logic [DistW-1:0]  nearest_distance_q;
  logic              found_q;
  logic              within_limit_q;
  logic [OpacW-1:0]  opacity_q;

  logic              in_fire;
  logic              ram_we;
  logic              scan_start;
  logic              scan_done;
  logic              fade_start;
  logic              fade_done;
  logic              out_free;
  logic              out_load;
  logic [AddrW-1:0]  ram_raddr;
  logic [EntryW-1:0] ram_rdata;
  scan_res_t         scan_res;
  fade_res_t         fade_res;

  assign in_ready_o = (state_q == TopIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign ram_we     = in_fire && (command_i == CmdWrite) && (int'(entry_index_i) < MaxPoints);
  assign scan_start = in_fire && (command_i == CmdQuery);
  assign out_free   = !out_valid_q || out_ready_i;

  wnpf_ram #(
    .Width (EntryW),
    .Depth (MaxPoints)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(entry_index_i)),
    .wdata_i (EntryW'({latitude_i, longitude_i})),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  wnpf_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .qlon_i  (longitude_i),
    .qlat_i  (latitude_i),
    .count_i (point_count_q),
    .raddr_o (ram_raddr),
    .rdata_i (ram_rdata),
    .done_o  (scan_done),
    .res_o   (scan_res)
  );

  wnpf_fade u_fade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fade_start),
    .scan_i  (scan_res),
    .lim_i   (dist_limit_q),
    .done_o  (fade_done),
    .res_o   (fade_res)
  );

  always_comb begin
    state_d     = state_q;
    fade_start  = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      TopIdle: begin
        if (scan_start) begin
          state_d = TopScan;
        end
      end
      TopScan: begin
        if (scan_done) begin
          fade_start = 1'b1;
          state_d    = TopFade;
        end
      end
      TopFade: begin
        if (fade_done) begin
          state_d = TopOut;
        end
      end
      TopOut: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = TopIdle;
        end
      end
      default: begin
        state_d = TopIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= TopIdle;
      out_valid_q   <= 1'b0;
      point_count_q <= '0;
      dist_limit_q  <= LimitReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgPointCount: point_count_q <= cfg_wdata_i[CountW-1:0];
          CfgDistLimit:  dist_limit_q  <= cfg_wdata_i[LimW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      nearest_index_q    <= IdxW'(scan_res.idx);
      nearest_distance_q <= fade_res.distance;
      found_q            <= scan_res.found;
      within_limit_q     <= fade_res.in_limit;
      opacity_q          <= fade_res.opacity;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign nearest_index_o    = nearest_index_q;
  assign nearest_distance_o = nearest_distance_q;
  assign found_o            = found_q;
  assign within_limit_o     = within_limit_q;
  assign opacity_o          = opacity_q;

  a_fade_done_in_fade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fade_done |-> (state_q == TopFade))
    else $error("Fade unit finished outside the fade phase.");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == TopOut) && out_free) |=> (out_valid_q && (state_q == TopIdle)))
    else $error("Finished query did not reach the output register.");

endmodule
